@@ sv/xmodem_receiver_macros.svh @@
// Assertion macros shared by the receiver modules.
// Expects clk and rst_n in the scope of each use.
`ifndef XMODEM_RECEIVER_MACROS_SVH
`define XMODEM_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define XMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/xmr_pkg.sv @@
// Types and byte codes for the XMODEM receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package xmr_pkg;

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd20;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd3000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_STOP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_RETRY_LIMIT   = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] pkt;
    logic [6:0] idx;
    logic       fin;
    logic       ok;
  } res_t;

endpackage
`default_nettype wire

@@ sv/xmr_in_stage.sv @@
// Input register for received requests.
// Depends on xmr_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none
module xmr_in_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s_valid,
  output logic              s_ready,
  input  wire xmr_pkg::req_t s_req,
  input  wire logic [7:0]   s_byte,
  input  wire logic         space,
  output logic              item_valid,
  output logic              take,
  output xmr_pkg::req_t     item_req,
  output logic [7:0]        item_byte
);
  import xmr_pkg::*;

  logic       valid_r, valid_nxt;
  req_t       req_r;
  logic [7:0] byte_r;
  logic       load;

  assign take      = valid_r && space;
  assign s_ready   = !valid_r || space;
  assign load      = s_valid && s_ready;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      req_r  <= s_req;
      byte_r <= s_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_req   = req_r;
  assign item_byte  = byte_r;

endmodule
`default_nettype wire

@@ sv/xmr_core.sv @@
// Receiver state and single-pass decision logic for one request.
// Depends on xmr_pkg and xmodem_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_receiver_macros.svh"
module xmr_core #(
  parameter int PACKET_BYTES = 132
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire xmr_pkg::req_t req,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    retry_limit,
  input  wire logic [15:0]   timeout_ticks,
  output logic               res_valid,
  output xmr_pkg::res_t      res
);
  import xmr_pkg::*;

  logic        active_r, active_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  pkt_r, pkt_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic        done_r, done_nxt;
  logic        ok_r, ok_nxt;

  logic [15:0] tick_inc;
  logic [7:0]  retry_inc;
  logic        pkt_end;

  assign tick_inc  = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign retry_inc = (retry_r == 8'hFF) ? retry_r : retry_r + 8'd1;
  assign pkt_end   = ({1'b0, pos_r} + 9'd1) >= 9'(PACKET_BYTES);

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    pkt_nxt    = pkt_r;
    tick_nxt   = tick_r;
    retry_nxt  = retry_r;
    done_nxt   = done_r;
    ok_nxt     = ok_r;
    res_valid  = 1'b0;
    res.kind   = KIND_TX;
    res.data   = 8'h00;
    res.idx    = 7'd0;
    res.fin    = 1'b0;
    res.ok     = 1'b0;

    if (take) begin
      case (req)
        REQ_START: begin
          active_nxt = 1'b1;
          pos_nxt    = 8'd0;
          pkt_nxt    = 8'd0;
          tick_nxt   = 16'd0;
          retry_nxt  = 8'd0;
          done_nxt   = 1'b0;
          ok_nxt     = 1'b0;
          res_valid  = 1'b1;
          res.data   = BYTE_NAK;
        end
        REQ_STOP: begin
          if (active_r) begin
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
            ok_nxt     = 1'b0;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.fin    = 1'b1;
          end
        end
        REQ_TICK: begin
          if (active_r) begin
            if (tick_inc < timeout_ticks) begin
              tick_nxt = tick_inc;
            end else begin
              // Timeout: drop the partial packet and NAK
              tick_nxt  = 16'd0;
              pos_nxt   = 8'd0;
              retry_nxt = retry_inc;
              res_valid = 1'b1;
              res.data  = BYTE_NAK;
              if (retry_inc > retry_limit) begin
                active_nxt = 1'b0;
                done_nxt   = 1'b1;
                ok_nxt     = 1'b0;
                res.fin    = 1'b1;
              end
            end
          end
        end
        REQ_BYTE: begin
          if (active_r) begin
            if (pos_r == 8'd0) begin
              if (rx_byte == BYTE_SOH) begin
                pos_nxt = 8'd1;
              end else if (rx_byte == BYTE_EOT || rx_byte == BYTE_CAN) begin
                active_nxt = 1'b0;
                done_nxt   = 1'b1;
                ok_nxt     = (rx_byte == BYTE_EOT);
                res_valid  = 1'b1;
                res.data   = BYTE_ACK;
                res.fin    = 1'b1;
                res.ok     = (rx_byte == BYTE_EOT);
              end else begin
                tick_nxt = 16'd0;
              end
            end else if (pkt_end) begin
              // Check byte: commit the packet
              pos_nxt   = 8'd0;
              tick_nxt  = 16'd0;
              res_valid = 1'b1;
              res.data  = BYTE_ACK;
            end else if (pos_r == 8'd1) begin
              pkt_nxt = rx_byte;
              pos_nxt = 8'd2;
            end else if (pos_r == 8'd2) begin
              pos_nxt = 8'd3;
            end else begin
              pos_nxt   = pos_r + 8'd1;
              res_valid = 1'b1;
              res.kind  = KIND_DATA;
              res.data  = rx_byte;
              res.idx   = 7'(pos_r - 8'd3);
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.pkt = pkt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= 8'd0;
      pkt_r    <= 8'd0;
      tick_r   <= 16'd0;
      retry_r  <= 8'd0;
      done_r   <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      pkt_r    <= pkt_nxt;
      tick_r   <= tick_nxt;
      retry_r  <= retry_nxt;
      done_r   <= done_nxt;
      ok_r     <= ok_nxt;
    end
  end

  `XMR_ASSERT_NOW(a_done_idle, done_r, !active_r, "finished transfer still active")
  `XMR_ASSERT_NOW(a_ok_done, ok_r, done_r, "success flag without finish")
  `XMR_ASSERT_NOW(a_pos_range, 1'b1, ({1'b0, pos_r} < 9'(PACKET_BYTES)), "position past packet")
  `XMR_ASSERT_NEXT(a_start_arms, take && req == REQ_START, active_r && retry_r == 8'd0, "start did not arm")

endmodule
`default_nettype wire

@@ sv/xmr_out_stage.sv @@
// Result register with a skid entry, feeding the result channel.
// Depends on xmr_pkg and xmodem_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_receiver_macros.svh"
module xmr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire xmr_pkg::res_t push_res,
  output logic               space,
  output logic               m_valid,
  input  wire logic          m_ready,
  output xmr_pkg::res_t      m_res
);
  import xmr_pkg::*;

  logic hv_r, hv_nxt;
  logic sv_r, sv_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop, head_free;

  assign pop       = hv_r && m_ready;
  assign head_free = !hv_r || pop;
  assign space     = !sv_r;

  always_comb begin
    hv_nxt   = hv_r;
    sv_nxt   = sv_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (head_free) begin
      if (sv_r) begin
        // Advance skid into head, refill skid
        head_nxt = skid_r;
        hv_nxt   = 1'b1;
        sv_nxt   = push;
        skid_nxt = push_res;
      end else begin
        head_nxt = push_res;
        hv_nxt   = push;
      end
    end else if (push) begin
      skid_nxt = push_res;
      sv_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign m_valid = hv_r;
  assign m_res   = head_r;

  `XMR_ASSERT_NOW(a_no_overrun, push, !sv_r, "result pushed into full stage")
  `XMR_ASSERT_NOW(a_skid_order, sv_r, hv_r, "skid holds a result while head is empty")

endmodule
`default_nettype wire

@@ sv/xmodem_receiver.sv @@
// Top level of the XMODEM receiver: configuration registers and channel wiring.
// Depends on xmr_pkg, xmr_in_stage, xmr_core and xmr_out_stage.
//
//   channel   direction  handshake             payload
//   in_       request    in_tvalid/in_tready   tdata: rx_byte; tuser: req_type
//   out_      result     out_tvalid/out_tready tdata/tuser/tlast: result fields
//   cfg_      config     APB, pready tied high retry_limit @0, timeout_ticks @4
//
// One request is accepted every cycle unless the result channel stalls. A result,
// if the request makes one, passes through the input register and then the result
// register before it can be taken.
// The rate is set by the single decision pass in the core between the two.
// A stalled result channel fills the result register and its skid entry; the
// input register then holds the next request and in_tready drops until
// out_tready frees a place.
// Reset (rst_n low, synchronous) clears control state and reloads the
// configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module xmodem_receiver #(
  parameter int PACKET_BYTES = 132
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [15:8] packet_number,
                                       // [22:16] data_index, [23] zero
  output logic [2:0]       out_tuser,  // [1:0] out_kind, [2] success
  output logic             out_tlast,  // finished
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import xmr_pkg::*;

  logic [7:0]  retry_limit_r, retry_limit_nxt;
  logic [15:0] timeout_ticks_r, timeout_ticks_nxt;
  logic        cfg_wr;
  reg_idx_t    cfg_sel;

  logic       item_valid, take, space, res_valid;
  req_t       item_req;
  logic [7:0] item_byte;
  res_t       core_res, out_res;

  // Configuration: write on the access phase, register picked by paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    retry_limit_nxt   = retry_limit_r;
    timeout_ticks_nxt = timeout_ticks_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_RETRY_LIMIT:   retry_limit_nxt   = cfg_pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks_nxt = cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r   <= RETRY_LIMIT_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else begin
      retry_limit_r   <= retry_limit_nxt;
      timeout_ticks_r <= timeout_ticks_nxt;
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RETRY_LIMIT:   cfg_prdata = {24'd0, retry_limit_r};
      REG_TIMEOUT_TICKS: cfg_prdata = {16'd0, timeout_ticks_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // Hold the accepted request until the core can place its result
  xmr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .s_req      (req_t'(in_tuser)),
    .s_byte     (in_tdata),
    .space      (space),
    .item_valid (item_valid),
    .take       (take),
    .item_req   (item_req),
    .item_byte  (item_byte)
  );

  xmr_core #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take && item_valid),
    .req           (item_req),
    .rx_byte       (item_byte),
    .retry_limit   (retry_limit_r),
    .timeout_ticks (timeout_ticks_r),
    .res_valid     (res_valid),
    .res           (core_res)
  );

  // Requests that make no result are consumed without a push
  xmr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (core_res),
    .space    (space),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_res    (out_res)
  );

  assign out_tdata = {1'b0, out_res.idx, out_res.pkt, out_res.data};
  assign out_tuser = {out_res.ok, out_res.kind};
  assign out_tlast = out_res.fin;

endmodule
`default_nettype wire

@@ tb/tb_xmodem_receiver.sv @@
// Self-checking bench for the XMODEM receiver: directed and random request streams.
// Needs xmr_pkg and xmodem_receiver; predicts every result internally and checks in order.
`timescale 1ns / 1ps
module tb_xmodem_receiver;
  import xmr_pkg::*;

  localparam int PKT_LEN       = 132;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 8;        // margin for the input and result registers to empty
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD_AT  = 150;      // results seen before the long sink hold-off
  localparam int LONG_HOLD_LEN = 400;

  typedef struct packed {
    req_t       req;
    logic [7:0] b;
  } rx_request_t;

  typedef enum int {SINK_READY, SINK_RANDOM, SINK_SLOW, SINK_TOGGLE} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = REQ_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  xmodem_receiver #(.PACKET_BYTES(PKT_LEN)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be accepted, and results still owed by the block
  rx_request_t pending_requests[$];
  res_t        expected_results[$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int issued_count    = 0;
  int cycle_count     = 0;

  // Predictor copy of the configuration and transfer state
  logic [7:0]  retry_limit_cfg = RETRY_LIMIT_RST;
  logic [15:0] timeout_cfg     = TIMEOUT_TICKS_RST;
  logic        xfer_active = 1'b0;
  logic [7:0]  pkt_pos     = 8'd0;
  logic [7:0]  cur_packet  = 8'd0;
  logic [15:0] tick_cnt    = 16'd0;
  logic [7:0]  retry_cnt   = 8'd0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d result %0d: %s", cycle_count, results_checked, msg);
    mismatch_count++;
  endtask

  function automatic void push_request(input req_t r, input logic [7:0] b);
    rx_request_t item;
    item.req = r;
    item.b   = b;
    pending_requests.push_back(item);
    issued_count++;
  endfunction

  function automatic void owe_result(input kind_t k, input logic [7:0] d, input logic [6:0] i,
                                     input logic fin, input logic ok);
    res_t r;
    r.kind = k;
    r.data = d;
    r.pkt  = cur_packet;
    r.idx  = i;
    r.fin  = fin;
    r.ok   = ok;
    expected_results.push_back(r);
  endfunction

  // Advance the transfer state by one accepted request and queue any result it owes
  function automatic void predict_request(input req_t req, input logic [7:0] b);
    case (req)
      REQ_START: begin
        xfer_active = 1'b1;
        pkt_pos     = 8'd0;
        cur_packet  = 8'd0;
        tick_cnt    = 16'd0;
        retry_cnt   = 8'd0;
        owe_result(KIND_TX, BYTE_NAK, 7'd0, 1'b0, 1'b0);
      end
      REQ_STOP: begin
        if (xfer_active) begin
          xfer_active = 1'b0;
          owe_result(KIND_STATUS, 8'h00, 7'd0, 1'b1, 1'b0);
        end
      end
      REQ_TICK: begin
        if (xfer_active) begin
          if (tick_cnt != 16'hFFFF) tick_cnt++;
          if (tick_cnt >= timeout_cfg) begin
            // timeout: drop the partial packet and count a retry
            tick_cnt = 16'd0;
            pkt_pos  = 8'd0;
            if (retry_cnt != 8'hFF) retry_cnt++;
            if (retry_cnt > retry_limit_cfg) begin
              xfer_active = 1'b0;
              owe_result(KIND_TX, BYTE_NAK, 7'd0, 1'b1, 1'b0);
            end else begin
              owe_result(KIND_TX, BYTE_NAK, 7'd0, 1'b0, 1'b0);
            end
          end
        end
      end
      default: begin
        if (!xfer_active) begin
          // idle: ignore the byte
        end else if (pkt_pos == 8'd0) begin
          if (b == BYTE_SOH) begin
            pkt_pos = 8'd1;
          end else if (b == BYTE_EOT) begin
            xfer_active = 1'b0;
            owe_result(KIND_TX, BYTE_ACK, 7'd0, 1'b1, 1'b1);
          end else if (b == BYTE_CAN) begin
            xfer_active = 1'b0;
            owe_result(KIND_TX, BYTE_ACK, 7'd0, 1'b1, 1'b0);
          end else begin
            tick_cnt = 16'd0;
          end
        end else if ({1'b0, pkt_pos} + 9'd1 >= PKT_LEN) begin
          // check byte closes the packet
          pkt_pos  = 8'd0;
          tick_cnt = 16'd0;
          owe_result(KIND_TX, BYTE_ACK, 7'd0, 1'b0, 1'b0);
        end else if (pkt_pos == 8'd1) begin
          cur_packet = b;
          pkt_pos    = 8'd2;
        end else if (pkt_pos == 8'd2) begin
          pkt_pos = 8'd3;
        end else begin
          owe_result(KIND_DATA, b, 7'(pkt_pos - 8'd3), 1'b0, 1'b0);
          pkt_pos = pkt_pos + 8'd1;
        end
      end
    endcase
  endfunction

  // Write a register over APB, then read it back
  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_RETRY_LIMIT) ? 32'h0000_00FF : 32'h0000_FFFF;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if ((cfg_prdata & mask) !== (value & mask))
      report_mismatch($sformatf("register %0d reads %0h, written %0h",
                                idx, cfg_prdata & mask, value & mask));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_RETRY_LIMIT) retry_limit_cfg = value[7:0];
    else timeout_cfg = value[15:0];
  endtask

  // Hold until every request is taken and every result is back, then let the pipe empty
  task automatic wait_quiet();
    while (pending_requests.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request source: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : request_source
    logic        nv;
    rx_request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_request(req_t'(in_tuser), in_tdata);
        pending_requests.delete(0);
      end
      // hold a request that has not been taken yet
      if (!(in_tvalid && !in_tready)) begin
        nv  = 1'b0;
        nxt = '0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          nv  = 1'b1;
          nxt = pending_requests[0];
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        in_tvalid <= nv;
        if (nv) begin
          in_tuser <= nxt.req;
          in_tdata <= nxt.b;
        end
      end
    end
  end

  // Result sink: check each taken result and stall on a changing pattern
  sink_mode_t sink_mode      = SINK_READY;
  int         mode_left      = 0;
  int         hold_left      = 0;
  bit         long_hold_done = 1'b0;

  always @(posedge clk) begin : result_sink
    res_t want;
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %0h",
                                    out_tuser[1:0], out_tdata[7:0]));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[1:0] !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_tuser[1:0], want.kind));
          if (out_tdata[7:0] !== want.data)
            report_mismatch($sformatf("byte %0h, expected %0h", out_tdata[7:0], want.data));
          if (out_tdata[15:8] !== want.pkt)
            report_mismatch($sformatf("packet %0h, expected %0h", out_tdata[15:8], want.pkt));
          if (out_tdata[22:16] !== want.idx)
            report_mismatch($sformatf("index %0d, expected %0d", out_tdata[22:16], want.idx));
          if (out_tdata[23] !== 1'b0)
            report_mismatch("padding bit set");
          if (out_tlast !== want.fin)
            report_mismatch($sformatf("finished %0b, expected %0b", out_tlast, want.fin));
          if (out_tuser[2] !== want.ok)
            report_mismatch($sformatf("success %0b, expected %0b", out_tuser[2], want.ok));
        end
        results_checked++;
      end
      // one long hold-off so the block backs up into its request channel
      if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
        hold_left      = LONG_HOLD_LEN;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (sink_mode)
          SINK_READY:  rdy = 1'b1;
          SINK_RANDOM: rdy = 1'($urandom_range(0, 1));
          SINK_SLOW:   rdy = ($urandom_range(0, 3) == 0);
          default:     rdy = ~out_tready;
        endcase
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase;
    int         n_pkts;
    int         cut;
    int         r;
    logic [7:0] seq_no;
    logic [7:0] num;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle requests, header handling, restart, cancel, end of file, stop
    push_request(REQ_STOP, 8'h00);
    push_request(REQ_TICK, 8'hFF);
    push_request(REQ_BYTE, 8'hFF);
    push_request(REQ_START, 8'h00);
    push_request(REQ_BYTE, BYTE_ACK);     // stray ACK byte in header slot: ignored
    push_request(REQ_BYTE, BYTE_NAK);     // stray NAK byte in header slot: ignored
    push_request(REQ_TICK, 8'h00);
    push_request(REQ_START, 8'hFF);       // restart while active
    push_request(REQ_BYTE, BYTE_CAN);
    push_request(REQ_BYTE, BYTE_SOH);     // after cancel: ignored
    push_request(REQ_START, 8'h00);
    push_request(REQ_BYTE, BYTE_EOT);
    push_request(REQ_START, 8'h00);
    push_request(REQ_BYTE, BYTE_SOH);
    push_request(REQ_BYTE, 8'hFF);
    push_request(REQ_BYTE, 8'h00);
    push_request(REQ_BYTE, 8'h00);
    push_request(REQ_BYTE, 8'hFF);
    push_request(REQ_STOP, 8'hFF);
    wait_quiet();

    // Directed: lowest limits, a partial packet times out and ends the transfer
    write_register(REG_RETRY_LIMIT, 32'd0);
    write_register(REG_TIMEOUT_TICKS, 32'd1);
    push_request(REQ_START, 8'h00);
    push_request(REQ_BYTE, BYTE_SOH);
    push_request(REQ_BYTE, 8'h7F);
    push_request(REQ_BYTE, 8'h80);
    push_request(REQ_BYTE, 8'h55);
    push_request(REQ_TICK, 8'hAA);
    wait_quiet();

    // Random phases: mostly well-formed transfers with random content
    phase = 0;
    while (issued_count < RANDOM_ITEMS) begin
      if (phase == 0) begin
        write_register(REG_RETRY_LIMIT, 32'd254);
        write_register(REG_TIMEOUT_TICKS, 32'd1);
        // run the retry counter up to the limit of 254 and past it
        push_request(REQ_START, 8'($urandom_range(0, 255)));
        repeat (256) push_request(REQ_TICK, 8'($urandom_range(0, 255)));
      end else if (phase == 1) begin
        write_register(REG_RETRY_LIMIT, 32'd0);
        write_register(REG_TIMEOUT_TICKS, 32'd65535);
      end else begin
        r = $urandom_range(0, 3);
        write_register(REG_RETRY_LIMIT, (r == 0) ? 32'd0 : (r == 1) ? 32'd254 :
                                        (r == 2) ? 32'd20 : $urandom_range(1, 4));
        r = $urandom_range(0, 3);
        write_register(REG_TIMEOUT_TICKS, (r == 0) ? 32'd1 : (r == 1) ? 32'd65535 :
                                          (r == 2) ? 32'd3000 : $urandom_range(2, 40));
      end

      repeat ($urandom_range(1, 2)) begin
        push_request(REQ_START, 8'($urandom_range(0, 255)));
        n_pkts = $urandom_range(0, 4);
        seq_no = 8'd1;
        for (int p = 0; p < n_pkts; p++) begin
          // noise in the header slot
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              do r = $urandom_range(0, 255);
              while (r == BYTE_SOH || r == BYTE_EOT || r == BYTE_CAN);
              push_request(REQ_BYTE, 8'(r));
            end
          end
          cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, PKT_LEN - 1) : PKT_LEN;
          num = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : seq_no;
          for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 39) == 0)
              push_request(REQ_TICK, 8'($urandom_range(0, 255)));
            if (k == 0)      push_request(REQ_BYTE, BYTE_SOH);
            else if (k == 1) push_request(REQ_BYTE, num);
            else if (k == 2) push_request(REQ_BYTE, ~num);
            else             push_request(REQ_BYTE, 8'($urandom_range(0, 255)));
          end
          // let a cut packet time out where the timeout is short enough
          if (cut != PKT_LEN && timeout_cfg <= 64)
            repeat (timeout_cfg) push_request(REQ_TICK, 8'($urandom_range(0, 255)));
          seq_no = seq_no + 8'd1;
        end
        r = $urandom_range(0, 7);
        if (r <= 3)      push_request(REQ_BYTE, BYTE_EOT);
        else if (r == 4) push_request(REQ_BYTE, BYTE_CAN);
        else if (r == 5) push_request(REQ_STOP, 8'($urandom_range(0, 255)));
        else if (r == 6)
          repeat ($urandom_range(1, 5)) push_request(REQ_TICK, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
          push_request(req_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      end
      wait_quiet();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/xmr_pkg.sv
sv/xmr_in_stage.sv
sv/xmr_core.sv
sv/xmr_out_stage.sv
sv/xmodem_receiver.sv
tb/tb_xmodem_receiver.sv
